// ===== design/osm_pkg.sv =====
// Shared types, codes and constants for the operand stack unit.
`default_nettype none

package osm_pkg;

    localparam int STACK_ENTRIES_DEF = 256;
    localparam int DATA_WIDTH_DEF    = 32;

    localparam int MODE_W  = 5;
    localparam int PUSH_W  = 32;
    localparam int PROT_W  = 9;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 9;
    localparam int TOP_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        M_PUSH   = 5'd0,
        M_CLEAR  = 5'd1,
        M_DEPTH  = 5'd2,
        M_DROP   = 5'd3,
        M_DROP2  = 5'd4,
        M_DROPN  = 5'd5,
        M_DUP    = 5'd6,
        M_DUP2   = 5'd7,
        M_DUPDUP = 5'd8,
        M_DUPN   = 5'd9,
        M_NDUPN  = 5'd10,
        M_NIP    = 5'd11,
        M_OVER   = 5'd12,
        M_PICK   = 5'd13,
        M_PICK3  = 5'd14,
        M_ROLL   = 5'd15,
        M_ROLLD  = 5'd16,
        M_ROT    = 5'd17,
        M_SWAP   = 5'd18,
        M_UNPICK = 5'd19,
        M_UNROT  = 5'd20
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        E_OK     = 3'd0,
        E_ARGS   = 3'd1,
        E_INDEX  = 3'd2,
        E_OVFL   = 3'd3,
        E_OPCODE = 3'd4
    } t_err;

    typedef enum logic [1:0] {RD_L1, RD_L2, RD_L3, RD_DEEP} t_rsel;

    typedef enum logic [2:0] {
        WA_P0, WA_P1, WA_M1, WA_M2, WA_M3, WA_DEEP, WA_UNPICK
    } t_wasel;

    typedef enum logic [2:0] {
        WD_PUSH, WD_DEPTH, WD_A, WD_B, WD_C, WD_P, WD_Q
    } t_wdsel;

    typedef enum logic [3:0] {
        SP_HOLD, SP_INC1, SP_INC2, SP_DEC1, SP_DEC2,
        SP_DROPN, SP_CLEAR, SP_DUPN, SP_NDUPN
    } t_spsel;

    typedef enum logic [1:0] {LP_ROLL, LP_ROLLD, LP_DUPN, LP_FILL} t_loop;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [PUSH_W-1:0] push_value;
    } t_in_req;

    typedef struct packed {
        logic [ERR_W-1:0]        error_code;
        logic [DEPTH_W-1:0]      stack_depth;
        logic signed [TOP_W-1:0] top_value;
    } t_out_resp;

    typedef struct packed {
        logic   in_load;
        logic   rd_en;
        t_rsel  rd_sel;
        logic   wr_en;
        t_wasel wa_sel;
        t_wdsel wd_sel;
        t_spsel sp_sel;
        logic   cap_a;
        logic   cap_b;
        logic   cap_c;
        logic   cap_p;
        logic   lp_start;
        t_loop  lp_kind;
        logic   res_load;
        t_err   err;
    } t_dp_cmd;

    typedef struct packed {
        logic d_ge1;
        logic d_ge2;
        logic d_ge3;
        logic room_ge1;
        logic room_ge2;
        logic n_neg;
        logic n_zero;
        logic n_ge_d;
        logic n_p1_ge_d;
        logic n_gt_room1;
        logic lp_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/osm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module osm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/osm_datapath.sv =====
// Stack datapath: pointer, operand registers, move loop, RAM and result register.
`default_nettype none

module osm_datapath
    import osm_pkg::*;
#(
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_status                    o_status,
    input  wire logic signed [PUSH_W-1:0] i_push_value,
    input  wire logic                     i_cfg_we,
    input  wire logic [PROT_W-1:0]        i_cfg_wdata,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output t_out_resp                     o_out_resp
);

    localparam int AW  = $clog2(STACK_ENTRIES);
    localparam int SPW = $clog2(STACK_ENTRIES + 1);
    localparam int NW  = $clog2(STACK_ENTRIES + 2);
    localparam int XW  = (NW > PROT_W) ? NW : PROT_W;
    localparam int MW  = ((DATA_WIDTH > XW) ? DATA_WIDTH : XW) + 1;

    logic signed [PUSH_W-1:0] r_pv;
    logic [DATA_WIDTH-1:0]    r_a, r_b, r_c, r_p;
    logic [SPW-1:0]           r_sp, n_sp;
    logic [PROT_W-1:0]        r_prot;
    logic [AW-1:0]            r_lp_src, r_lp_ofs, r_pend_addr;
    logic                     r_lp_down, r_lp_fill, r_pend;
    logic [NW-1:0]            r_lp_cnt;
    logic                     r_ov;
    t_out_resp                r_out;

    logic [XW-1:0]         d;
    logic [SPW-1:0]        room;
    logic [NW-1:0]         n_low, extra;
    logic [MW-1:0]         n_mw, d_mw;
    logic [AW-1:0]         sp_a, n_a;
    logic                  lp_rd, lp_fill_wr;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr, cmd_waddr, cmd_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_q, cmd_wdata;

    assign d     = (XW'(r_sp) > XW'(r_prot)) ? XW'(r_sp) - XW'(r_prot) : '0;
    assign room  = SPW'(STACK_ENTRIES) - r_sp;
    assign n_low = NW'(r_a);
    assign extra = (n_low == '0) ? '0 : n_low - NW'(1);
    assign n_mw  = MW'(r_a);
    assign d_mw  = MW'(d);
    assign sp_a  = AW'(r_sp);
    assign n_a   = AW'(n_low);

    always_comb begin
        o_status.d_ge1      = d != '0;
        o_status.d_ge2      = d >= XW'(2);
        o_status.d_ge3      = d >= XW'(3);
        o_status.room_ge1   = room != '0;
        o_status.room_ge2   = room >= SPW'(2);
        o_status.n_neg      = r_a[DATA_WIDTH-1];
        o_status.n_zero     = r_a == '0;
        o_status.n_ge_d     = n_mw >= d_mw;
        o_status.n_p1_ge_d  = (n_mw + MW'(1)) >= d_mw;
        o_status.n_gt_room1 = n_mw > (MW'(room) + MW'(1));
        o_status.lp_done    = (r_lp_cnt == '0) && !r_pend;
        o_status.out_free   = !r_ov || !i_out_stall;
    end

    // Command address and data selection.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_L1:   cmd_raddr = sp_a - AW'(1);
            RD_L2:   cmd_raddr = sp_a - AW'(2);
            RD_L3:   cmd_raddr = sp_a - AW'(3);
            RD_DEEP: cmd_raddr = sp_a - AW'(1) - n_a;
            default: cmd_raddr = sp_a - AW'(1);
        endcase
        case (i_cmd.wa_sel)
            WA_P0:     cmd_waddr = sp_a;
            WA_P1:     cmd_waddr = sp_a + AW'(1);
            WA_M1:     cmd_waddr = sp_a - AW'(1);
            WA_M2:     cmd_waddr = sp_a - AW'(2);
            WA_M3:     cmd_waddr = sp_a - AW'(3);
            WA_DEEP:   cmd_waddr = sp_a - AW'(1) - n_a;
            WA_UNPICK: cmd_waddr = sp_a - AW'(2) - n_a;
            default:   cmd_waddr = sp_a;
        endcase
        case (i_cmd.wd_sel)
            WD_PUSH:  cmd_wdata = DATA_WIDTH'(r_pv);
            WD_DEPTH: cmd_wdata = DATA_WIDTH'(d);
            WD_A:     cmd_wdata = r_a;
            WD_B:     cmd_wdata = r_b;
            WD_C:     cmd_wdata = r_c;
            WD_P:     cmd_wdata = r_p;
            WD_Q:     cmd_wdata = ram_q;
            default:  cmd_wdata = r_a;
        endcase
    end

    // Loop owns the RAM while it runs.
    assign lp_rd      = !r_lp_fill && (r_lp_cnt != '0);
    assign lp_fill_wr = r_lp_fill && (r_lp_cnt != '0);

    always_comb begin
        ram_re    = i_cmd.rd_en || lp_rd;
        ram_raddr = lp_rd ? r_lp_src : cmd_raddr;
        if (r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_addr;
            ram_wdata = ram_q;
        end else if (lp_fill_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_lp_src;
            ram_wdata = (r_lp_cnt == NW'(1)) ? r_a : r_b;
        end else begin
            ram_we    = i_cmd.wr_en;
            ram_waddr = cmd_waddr;
            ram_wdata = cmd_wdata;
        end
    end

    always_comb begin
        case (i_cmd.sp_sel)
            SP_HOLD:  n_sp = r_sp;
            SP_INC1:  n_sp = r_sp + SPW'(1);
            SP_INC2:  n_sp = r_sp + SPW'(2);
            SP_DEC1:  n_sp = r_sp - SPW'(1);
            SP_DEC2:  n_sp = r_sp - SPW'(2);
            SP_DROPN: n_sp = r_sp - SPW'(n_low) - SPW'(1);
            SP_CLEAR: n_sp = (XW'(r_sp) > XW'(r_prot)) ? SPW'(r_prot) : r_sp;
            SP_DUPN:  n_sp = r_sp - SPW'(1) + SPW'(n_low);
            SP_NDUPN: n_sp = r_sp + SPW'(extra);
            default:  n_sp = r_sp;
        endcase
    end

    osm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_prot    <= '0;
            r_lp_cnt  <= '0;
            r_lp_fill <= 1'b0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_sp <= n_sp;
            if (i_cfg_we) begin
                r_prot <= i_cfg_wdata;
            end
            if (i_cmd.lp_start) begin
                r_pend    <= 1'b0;
                r_lp_fill <= i_cmd.lp_kind == LP_FILL;
                case (i_cmd.lp_kind)
                    LP_ROLL:  r_lp_cnt <= n_low - NW'(1);
                    LP_ROLLD: r_lp_cnt <= n_low - NW'(1);
                    LP_DUPN:  r_lp_cnt <= n_low;
                    LP_FILL:  r_lp_cnt <= extra + NW'(1);
                    default:  r_lp_cnt <= '0;
                endcase
            end else begin
                r_pend <= lp_rd;
                if (lp_rd || lp_fill_wr) begin
                    r_lp_cnt <= r_lp_cnt - NW'(1);
                end
            end
            if (i_cmd.res_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_pv <= i_push_value;
        end
        if (i_cmd.cap_a) begin
            r_a <= ram_q;
        end
        if (i_cmd.cap_b) begin
            r_b <= ram_q;
        end
        if (i_cmd.cap_c) begin
            r_c <= ram_q;
        end
        if (i_cmd.cap_p) begin
            r_p <= ram_q;
        end
        if (i_cmd.lp_start) begin
            case (i_cmd.lp_kind)
                LP_ROLL: begin
                    r_lp_src  <= sp_a - n_a;
                    r_lp_ofs  <= '1;
                    r_lp_down <= 1'b0;
                end
                LP_ROLLD: begin
                    r_lp_src  <= sp_a - AW'(3);
                    r_lp_ofs  <= AW'(1);
                    r_lp_down <= 1'b1;
                end
                LP_DUPN: begin
                    r_lp_src  <= sp_a - AW'(1) - n_a;
                    r_lp_ofs  <= n_a;
                    r_lp_down <= 1'b0;
                end
                default: begin
                    r_lp_src  <= sp_a - AW'(1);
                    r_lp_ofs  <= '0;
                    r_lp_down <= 1'b0;
                end
            endcase
        end else if (lp_rd) begin
            r_pend_addr <= r_lp_src + r_lp_ofs;
            r_lp_src    <= r_lp_down ? r_lp_src - AW'(1) : r_lp_src + AW'(1);
        end else if (lp_fill_wr) begin
            r_lp_src <= r_lp_src + AW'(1);
        end
        if (i_cmd.res_load) begin
            r_out.error_code  <= i_cmd.err;
            r_out.stack_depth <= DEPTH_W'(d);
            r_out.top_value   <= (r_sp == '0) ? '0 : TOP_W'(ram_q);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_resp  = r_out;

    a_sp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_ENTRIES))
        else $error("stack pointer beyond stack size");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend || lp_fill_wr) |-> !i_cmd.wr_en)
        else $error("command write while the move loop owns the RAM");

    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |=> r_ov)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== design/osm_ctrl.sv =====
// Operation sequencer: decodes the mode, checks arguments, steps the datapath.
`default_nettype none

module osm_ctrl
    import osm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    output logic                   o_in_stall,
    input  wire t_dp_status        i_status,
    output t_dp_cmd                o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD2, S_RD3, S_CHK, S_EXEC, S_LOOP, S_FIN, S_TOP, S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    t_err        r_err, n_err, err_calc;
    logic [1:0]  r_step, n_step;

    // Argument checks, valid once level one sits in the datapath.
    always_comb begin
        err_calc = E_OK;
        case (r_mode)
            M_PUSH, M_DEPTH: if (!i_status.room_ge1) err_calc = E_OVFL;
            M_CLEAR: err_calc = E_OK;
            M_DROP: if (!i_status.d_ge1) err_calc = E_ARGS;
            M_DROP2, M_NIP, M_SWAP: if (!i_status.d_ge2) err_calc = E_ARGS;
            M_ROT, M_UNROT: if (!i_status.d_ge3) err_calc = E_ARGS;
            M_DROPN: begin
                if (!i_status.d_ge1) err_calc = E_ARGS;
                else if (i_status.n_neg || i_status.n_ge_d) err_calc = E_INDEX;
            end
            M_DUP: begin
                if (!i_status.d_ge1) err_calc = E_ARGS;
                else if (!i_status.room_ge1) err_calc = E_OVFL;
            end
            M_DUP2: begin
                if (!i_status.d_ge2) err_calc = E_ARGS;
                else if (!i_status.room_ge2) err_calc = E_OVFL;
            end
            M_DUPDUP: begin
                if (!i_status.d_ge1) err_calc = E_ARGS;
                else if (!i_status.room_ge2) err_calc = E_OVFL;
            end
            M_DUPN: begin
                if (!i_status.d_ge1) err_calc = E_ARGS;
                else if (i_status.n_neg || i_status.n_ge_d) err_calc = E_INDEX;
                else if (i_status.n_gt_room1) err_calc = E_OVFL;
            end
            M_NDUPN: begin
                if (!i_status.d_ge2) err_calc = E_ARGS;
                else if (i_status.n_neg) err_calc = E_INDEX;
                else if (i_status.n_gt_room1) err_calc = E_OVFL;
            end
            M_OVER: begin
                if (!i_status.d_ge2) err_calc = E_ARGS;
                else if (!i_status.room_ge1) err_calc = E_OVFL;
            end
            M_PICK3: begin
                if (!i_status.d_ge3) err_calc = E_ARGS;
                else if (!i_status.room_ge1) err_calc = E_OVFL;
            end
            M_PICK, M_ROLL, M_ROLLD: begin
                if (!i_status.d_ge1) err_calc = E_ARGS;
                else if (i_status.n_neg || i_status.n_zero || i_status.n_ge_d)
                    err_calc = E_INDEX;
            end
            M_UNPICK: begin
                if (!i_status.d_ge2) err_calc = E_ARGS;
                else if (i_status.n_neg || i_status.n_zero || i_status.n_p1_ge_d)
                    err_calc = E_INDEX;
            end
            default: err_calc = E_OPCODE;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_err      = r_err;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.err  = r_err;
        o_in_stall = r_state != S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_L1;
                    n_mode        = t_mode'(i_mode);
                    n_state       = S_RD2;
                end
            end
            S_RD2: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_L2;
                n_state      = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_L3;
                n_err        = err_calc;
                n_state      = S_CHK;
            end
            S_CHK: begin
                o_cmd.cap_c = 1'b1;
                n_step      = '0;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                n_step = r_step + 2'd1;
                if (r_err != E_OK) begin
                    n_state = S_TOP;
                end else begin
                    n_state = S_TOP;
                    case (r_mode)
                        M_PUSH: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_P0;
                            o_cmd.wd_sel = WD_PUSH;
                            o_cmd.sp_sel = SP_INC1;
                        end
                        M_CLEAR: o_cmd.sp_sel = SP_CLEAR;
                        M_DEPTH: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_P0;
                            o_cmd.wd_sel = WD_DEPTH;
                            o_cmd.sp_sel = SP_INC1;
                        end
                        M_DROP:  o_cmd.sp_sel = SP_DEC1;
                        M_DROP2: o_cmd.sp_sel = SP_DEC2;
                        M_DROPN: o_cmd.sp_sel = SP_DROPN;
                        M_DUP, M_OVER, M_PICK3: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_P0;
                            o_cmd.wd_sel = (r_mode == M_DUP)  ? WD_A :
                                           (r_mode == M_OVER) ? WD_B : WD_C;
                            o_cmd.sp_sel = SP_INC1;
                        end
                        M_DUP2, M_DUPDUP: begin
                            o_cmd.wr_en = 1'b1;
                            if (r_step == 2'd0) begin
                                o_cmd.wa_sel = WA_P0;
                                o_cmd.wd_sel = (r_mode == M_DUP2) ? WD_B : WD_A;
                                n_state      = S_EXEC;
                            end else begin
                                o_cmd.wa_sel = WA_P1;
                                o_cmd.wd_sel = WD_A;
                                o_cmd.sp_sel = SP_INC2;
                            end
                        end
                        M_DUPN: begin
                            o_cmd.lp_start = 1'b1;
                            o_cmd.lp_kind  = LP_DUPN;
                            n_state        = S_LOOP;
                        end
                        M_NDUPN: begin
                            o_cmd.lp_start = 1'b1;
                            o_cmd.lp_kind  = LP_FILL;
                            n_state        = S_LOOP;
                        end
                        M_NIP: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_M2;
                            o_cmd.wd_sel = WD_A;
                            o_cmd.sp_sel = SP_DEC1;
                        end
                        M_PICK: begin
                            if (r_step == 2'd0) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_DEEP;
                                n_state      = S_EXEC;
                            end else begin
                                o_cmd.wr_en  = 1'b1;
                                o_cmd.wa_sel = WA_M1;
                                o_cmd.wd_sel = WD_Q;
                            end
                        end
                        M_ROLL: begin
                            if (r_step == 2'd0) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_DEEP;
                                n_state      = S_EXEC;
                            end else begin
                                o_cmd.cap_p    = 1'b1;
                                o_cmd.lp_start = 1'b1;
                                o_cmd.lp_kind  = LP_ROLL;
                                n_state        = S_LOOP;
                            end
                        end
                        M_ROLLD: begin
                            o_cmd.lp_start = 1'b1;
                            o_cmd.lp_kind  = LP_ROLLD;
                            n_state        = S_LOOP;
                        end
                        M_ROT, M_UNROT, M_SWAP: begin
                            o_cmd.wr_en = 1'b1;
                            case (r_step)
                                2'd0: begin
                                    o_cmd.wa_sel = WA_M1;
                                    o_cmd.wd_sel = (r_mode == M_ROT) ? WD_C : WD_B;
                                    n_state      = S_EXEC;
                                end
                                2'd1: begin
                                    o_cmd.wa_sel = WA_M2;
                                    o_cmd.wd_sel = (r_mode == M_UNROT) ? WD_C : WD_A;
                                    if (r_mode != M_SWAP) n_state = S_EXEC;
                                end
                                default: begin
                                    o_cmd.wa_sel = WA_M3;
                                    o_cmd.wd_sel = (r_mode == M_ROT) ? WD_B : WD_A;
                                end
                            endcase
                        end
                        M_UNPICK: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_UNPICK;
                            o_cmd.wd_sel = WD_B;
                            o_cmd.sp_sel = SP_DEC2;
                        end
                        default: n_state = S_TOP;
                    endcase
                end
            end
            S_LOOP: begin
                if (i_status.lp_done) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_TOP;
                case (r_mode)
                    M_ROLL: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wa_sel = WA_M2;
                        o_cmd.wd_sel = WD_P;
                        o_cmd.sp_sel = SP_DEC1;
                    end
                    M_ROLLD: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wa_sel = WA_DEEP;
                        o_cmd.wd_sel = WD_B;
                        o_cmd.sp_sel = SP_DEC1;
                    end
                    M_DUPN:  o_cmd.sp_sel = SP_DUPN;
                    M_NDUPN: o_cmd.sp_sel = SP_NDUPN;
                    default: o_cmd.sp_sel = SP_HOLD;
                endcase
            end
            S_TOP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_L1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_PUSH;
            r_err   <= E_OK;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_err   <= n_err;
            r_step  <= n_step;
        end
    end

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_err != E_OK) |=> (r_state == S_TOP))
        else $error("flagged request did not skip execution");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RD2 && o_in_stall))
        else $error("accepted request did not start fetch");

    a_loop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (!o_cmd.wr_en && !o_cmd.rd_en))
        else $error("command RAM access during move loop");

endmodule

`default_nettype wire

// ===== design/operand_stack_manipulator.sv =====
// Top level of the operand stack unit: sequencer plus stack datapath.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        request    i_in_valid / o_in_stall   i_in_req  (mode, push_value)
//  out       result     o_out_valid / i_out_stall o_out_resp (error, depth, top)
//  cfg       write      i_cfg_we                  i_cfg_wdata (protect level)
//
// One request at a time. A request steps through the sequencer: three fetch reads
// on the single RAM read port, the argument check, k = 1..3 execute steps for the
// fixed operations with their writes, then one top-of-stack read. ROLL, ROLLD and
// DUPN add a move loop, NDUPN adds a fill loop that writes the pushed copies.
// Reset clears the pointer, protect level and result valid; stack RAM is not cleared.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits in its last state until the result register frees up.
`default_nettype none

module operand_stack_manipulator
    import osm_pkg::*;
#(
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_req           i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_resp              o_out_resp,
    input  wire logic              i_cfg_we,
    input  wire logic [PROT_W-1:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer: decode, argument check, step through reads, writes and loops.
    osm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_req.mode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: stack RAM, pointer, operand registers and result register.
    osm_datapath #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_push_value (i_in_req.push_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_resp   (o_out_resp)
    );

endmodule

`default_nettype wire
